// File: rtl/tmb_pkg.sv
// Shared types, command codes and reset limits for the timeout timer bank.
package tmb_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int TIME_W         = 32;
  localparam int CH_W           = 4;
  localparam int KIND_W         = 3;
  localparam int CNT_W          = 5;

  localparam logic [KIND_W-1:0] KIND_TICK     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_START    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STOP     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RESTART  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STOP_ALL = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CONFIG   = 3'd5;

  localparam logic [TIME_W-1:0] DEFAULT_LIMIT = 32'd1000;

  typedef struct packed {
    logic              recurring;
    logic [TIME_W-1:0] limit;
    logic [TIME_W-1:0] start;
  } entry_t;

  typedef struct packed {
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] remaining;
    logic              reached;
  } eval_t;

  function automatic logic [TIME_W-1:0] default_limit(input logic [31:0] ch);
    logic [TIME_W-1:0] lim;
    case (ch)
      32'd0:   lim = 32'd5000;
      32'd1:   lim = 32'd100;
      32'd2:   lim = 32'd1000;
      32'd3:   lim = 32'd500;
      32'd4:   lim = 32'd5000;
      32'd5:   lim = 32'd10000;
      32'd6:   lim = 32'd100;
      32'd7:   lim = 32'd1000;
      32'd8:   lim = 32'd30000;
      32'd9:   lim = 32'd50;
      default: lim = DEFAULT_LIMIT;
    endcase
    return lim;
  endfunction

endpackage

// File: rtl/tmb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/tmb_eval.sv
// Channel evaluator: elapsed time, remaining time and limit reached.
module tmb_eval (
  input  tmb_pkg::entry_t             ent,
  input  logic [tmb_pkg::TIME_W-1:0] now,
  output tmb_pkg::eval_t              ev
);
  import tmb_pkg::*;

  logic [TIME_W-1:0] elapsed;
  logic              reached;

  assign elapsed      = now - ent.start;
  assign reached      = (elapsed >= ent.limit);
  assign ev.elapsed   = elapsed;
  assign ev.reached   = reached;
  assign ev.remaining = reached ? '0 : (ent.limit - elapsed);

endmodule

// File: rtl/timeout_timer_bank_unit.sv
// Timeout timer bank: channel table in RAM, command sequencer and two-pass tick scan.
// Command: busy after the transfer until the unit returns to idle; its status strobes as it does.
// Tick: two passes over the channel RAM, one read a cycle;
//   a tick with no expiry ends after the first pass. Expiry reports strobe in the second.
// Results are shown for one cycle each; the receiver cannot stall.
// Reset (synchronous) clears time, counters and flags; per-entry written bits give reset values.
module timeout_timer_bank_unit #(
  parameter int NUM_TIMERS = tmb_pkg::NUM_TIMERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [tmb_pkg::KIND_W-1:0]  kind,
  input  logic [tmb_pkg::CH_W-1:0]    timer_index,
  input  logic [tmb_pkg::TIME_W-1:0]  limit_ms,
  input  logic                        recurring,
  output logic                        strobe,
  output logic [tmb_pkg::CH_W-1:0]    channel,
  output logic                        expiry_event,
  output logic [tmb_pkg::TIME_W-1:0]  elapsed_ms,
  output logic [tmb_pkg::TIME_W-1:0]  remaining_ms,
  output logic                        channel_active,
  output logic [tmb_pkg::CNT_W-1:0]   active_count,
  output logic [tmb_pkg::TIME_W-1:0]  total_expiries,
  output logic                        last
);
  import tmb_pkg::*;

  localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int SCAN_W = $clog2(NUM_TIMERS + 1);

  typedef enum logic [2:0] {S_IDLE, S_CMD, S_SCAN1, S_SCAN2} state_t;

  state_t              state;
  logic [TIME_W-1:0]   now;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    cnt_fin;
  logic [CNT_W-1:0]    drop;
  logic [TIME_W-1:0]   tot;
  logic [NUM_TIMERS-1:0] active;
  logic [NUM_TIMERS-1:0] written;

  logic [KIND_W-1:0]   k_kind;
  logic [CH_W-1:0]     k_idx;
  logic [IDX_W-1:0]    k_addr;
  logic                k_valid;
  logic [TIME_W-1:0]   k_lim;
  logic                k_rec;

  logic [SCAN_W-1:0]   s;
  logic                p_v;
  logic [IDX_W-1:0]    p_s;
  logic                exp_any;
  logic [IDX_W-1:0]    last_exp;

  logic                accept;
  logic [IDX_W+3:0]    in_ext;
  logic [IDX_W-1:0]    in_addr;
  logic [IDX_W+3:0]    ps_ext;
  logic                scan_end;

  logic [IDX_W-1:0]    raddr;
  logic [$bits(entry_t)-1:0] rdata;
  logic                we;
  logic [IDX_W-1:0]    waddr;
  entry_t              wdata;

  logic [IDX_W-1:0]    ent_idx;
  entry_t              eff;
  entry_t              new_ent;
  entry_t              rearm;
  entry_t              ev_in;
  eval_t               ev;
  logic                act_old;
  logic                new_act;
  logic [CNT_W-1:0]    cnt_cmd;
  logic                we_cmd;
  logic                p_exp;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign in_ext   = {{IDX_W{1'b0}}, timer_index};
  assign in_addr  = in_ext[IDX_W-1:0];
  assign ps_ext   = {4'b0, p_s};
  assign scan_end = (s == SCAN_W'(NUM_TIMERS)) && !p_v;

  assign raddr   = (state == S_IDLE) ? in_addr : s[IDX_W-1:0];
  assign ent_idx = (state == S_CMD) ? k_addr : p_s;

  always_comb begin
    if (written[ent_idx]) begin
      eff = entry_t'(rdata);
    end else begin
      eff.recurring = 1'b0;
      eff.limit     = default_limit(32'(ent_idx));
      eff.start     = '0;
    end
  end

  always_comb begin
    act_old = active[k_addr];
    new_ent = eff;
    new_act = act_old;
    cnt_cmd = cnt;
    we_cmd  = 1'b0;
    case (k_kind)
      KIND_START: begin
        if (k_valid && !act_old) begin
          new_ent.start = now;
          new_act       = 1'b1;
          cnt_cmd       = cnt + 1'b1;
          we_cmd        = 1'b1;
        end
      end
      KIND_STOP: begin
        if (k_valid && act_old) begin
          new_act = 1'b0;
          cnt_cmd = cnt - 1'b1;
        end
      end
      KIND_RESTART: begin
        if (k_valid) begin
          new_ent.start = now;
          we_cmd        = 1'b1;
          if (!act_old) begin
            new_act = 1'b1;
            cnt_cmd = cnt + 1'b1;
          end
        end
      end
      KIND_STOP_ALL: begin
        new_act = 1'b0;
        cnt_cmd = '0;
      end
      KIND_CONFIG: begin
        if (k_valid) begin
          new_ent.limit     = k_lim;
          new_ent.recurring = k_rec;
          we_cmd            = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rearm       = eff;
    rearm.start = now;
  end

  assign ev_in = (state == S_CMD) ? new_ent : eff;
  assign p_exp = p_v && active[p_s] && ev.reached;

  assign we    = ((state == S_CMD) && we_cmd) ||
                 ((state == S_SCAN2) && p_exp && eff.recurring);
  assign waddr = (state == S_CMD) ? k_addr : p_s;
  assign wdata = (state == S_CMD) ? new_ent : rearm;

  tmb_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_TIMERS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  tmb_eval u_eval (
    .ent (ev_in),
    .now (now),
    .ev  (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      now     <= '0;
      cnt     <= '0;
      tot     <= '0;
      active  <= '0;
      written <= '0;
      strobe  <= 1'b0;
      p_v     <= 1'b0;
      s       <= '0;
      exp_any <= 1'b0;
      drop    <= '0;
    end else begin
      strobe <= 1'b0;
      if (we) begin
        written[waddr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            k_kind  <= kind;
            k_idx   <= timer_index;
            k_addr  <= in_addr;
            k_valid <= (32'(timer_index) < 32'(NUM_TIMERS));
            k_lim   <= limit_ms;
            k_rec   <= recurring;
            if (kind == KIND_TICK) begin
              now     <= now + 1'b1;
              s       <= '0;
              p_v     <= 1'b0;
              exp_any <= 1'b0;
              drop    <= '0;
              state   <= S_SCAN1;
            end else begin
              state <= S_CMD;
            end
          end
        end
        S_CMD: begin
          if (k_kind == KIND_STOP_ALL) begin
            active <= '0;
          end else if (k_valid) begin
            active[k_addr] <= new_act;
          end
          cnt            <= cnt_cmd;
          strobe         <= 1'b1;
          channel        <= k_idx;
          expiry_event   <= 1'b0;
          elapsed_ms     <= k_valid ? ev.elapsed : '0;
          remaining_ms   <= k_valid ? ev.remaining : '0;
          channel_active <= k_valid && new_act;
          active_count   <= cnt_cmd;
          total_expiries <= tot;
          last           <= 1'b1;
          state          <= S_IDLE;
        end
        S_SCAN1: begin
          if (s != SCAN_W'(NUM_TIMERS)) begin
            s   <= s + 1'b1;
            p_v <= 1'b1;
            p_s <= s[IDX_W-1:0];
          end else begin
            p_v <= 1'b0;
          end
          if (p_exp) begin
            exp_any  <= 1'b1;
            last_exp <= p_s;
            if (!eff.recurring) begin
              drop <= drop + 1'b1;
            end
          end
          if (scan_end) begin
            if (exp_any) begin
              cnt_fin <= cnt - drop;
              s       <= '0;
              state   <= S_SCAN2;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_SCAN2: begin
          if (s != SCAN_W'(NUM_TIMERS)) begin
            s   <= s + 1'b1;
            p_v <= 1'b1;
            p_s <= s[IDX_W-1:0];
          end else begin
            p_v <= 1'b0;
          end
          if (p_exp) begin
            tot            <= tot + 1'b1;
            strobe         <= 1'b1;
            channel        <= ps_ext[3:0];
            expiry_event   <= 1'b1;
            elapsed_ms     <= ev.elapsed;
            remaining_ms   <= '0;
            channel_active <= eff.recurring;
            active_count   <= cnt_fin;
            total_expiries <= tot + 1'b1;
            last           <= (p_s == last_exp);
            if (!eff.recurring) begin
              active[p_s] <= 1'b0;
            end
          end
          if (scan_end) begin
            cnt   <= cnt_fin;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_matches_flags: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (cnt == CNT_W'($countones(active))))
    else $error("active count does not match active flags");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not raised after a transfer");

  a_cmd_status: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind != KIND_TICK)) |-> ##2 (strobe && !expiry_event && last))
    else $error("command status missing");

  a_expiry_zero_remaining: assert property (@(posedge clk) disable iff (rst)
    (strobe && expiry_event) |-> (remaining_ms == '0))
    else $error("expiry report with nonzero remaining time");

endmodule

// File: verif/tb_timeout_timer_bank_unit.sv
// Self-checking testbench for the timeout timer bank: directed table, then random commands.
module tb_timeout_timer_bank_unit;
  import tmb_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;
  localparam int CHANNELS    = 16;
  localparam int PLAN_ROWS   = 25;
  localparam int RANDOM_GOAL = 145;
  localparam int SETTLE      = 2 * (CHANNELS + 2) + 8;

  typedef struct packed {
    logic [CH_W-1:0]   chan;
    logic              expiry;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] remain;
    logic              active;
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] total;
    logic              is_last;
  } status_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CH_W-1:0]   idx;
    logic [TIME_W-1:0] lim;
    logic              rec;
    logic              typed;
    logic [TIME_W-1:0] el;
    logic [TIME_W-1:0] rem;
    logic              act;
    logic [CNT_W-1:0]  cnt;
    logic [TIME_W-1:0] tot;
  } plan_row_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [KIND_W-1:0]   kind;
  logic [CH_W-1:0]     timer_index;
  logic [TIME_W-1:0]   limit_ms;
  logic                recurring;
  logic                strobe;
  logic [CH_W-1:0]     channel;
  logic                expiry_event;
  logic [TIME_W-1:0]   elapsed_ms;
  logic [TIME_W-1:0]   remaining_ms;
  logic                channel_active;
  logic [CNT_W-1:0]    active_count;
  logic [TIME_W-1:0]   total_expiries;
  logic                last;

  timeout_timer_bank_unit dut (
    .clk, .rst, .start, .busy, .kind, .timer_index, .limit_ms, .recurring,
    .strobe, .channel, .expiry_event, .elapsed_ms, .remaining_ms,
    .channel_active, .active_count, .total_expiries, .last
  );

  logic [TIME_W-1:0] now_ticks;
  logic [TIME_W-1:0] armed_at [CHANNELS];
  logic [TIME_W-1:0] span     [CHANNELS];
  logic              running  [CHANNELS];
  logic              repeats  [CHANNELS];
  logic [CNT_W-1:0]  running_total;
  logic [TIME_W-1:0] fired_total;

  status_t   pending_status[$];
  plan_row_t plan [0:PLAN_ROWS-1];
  int        errors;
  int        sent;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic flag(input string msg);
    errors++;
    if (errors <= 100) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic bank_reset();
    now_ticks = '0;
    running_total = '0;
    fired_total = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      armed_at[i] = '0;
      running[i] = 1'b0;
      repeats[i] = 1'b0;
      span[i] = DEFAULT_LIMIT;
    end
    span[0] = 32'd5000;
    span[1] = 32'd100;
    span[2] = 32'd1000;
    span[3] = 32'd500;
    span[4] = 32'd5000;
    span[5] = 32'd10000;
    span[6] = 32'd100;
    span[7] = 32'd1000;
    span[8] = 32'd30000;
    span[9] = 32'd50;
  endtask

  task automatic bank_step(input logic [KIND_W-1:0] k, input logic [CH_W-1:0] ix,
                           input logic [TIME_W-1:0] lm, input logic r);
    status_t batch[$];
    status_t rep;
    logic [TIME_W-1:0] el;
    if (k == KIND_TICK) begin
      now_ticks++;
      for (int i = 0; i < CHANNELS; i++) begin
        if (running[i]) begin
          el = now_ticks - armed_at[i];
          if (el >= span[i]) begin
            fired_total++;
            if (repeats[i]) begin
              armed_at[i] = now_ticks;
            end else begin
              running[i] = 1'b0;
              running_total--;
            end
            rep = '{4'(i), 1'b1, el, '0, running[i], '0, fired_total, 1'b0};
            batch.push_back(rep);
          end
        end
      end
    end else begin
      case (k)
        KIND_STOP_ALL: begin
          for (int i = 0; i < CHANNELS; i++) running[i] = 1'b0;
          running_total = '0;
        end
        KIND_START: begin
          if (!running[ix]) begin
            armed_at[ix] = now_ticks;
            running[ix] = 1'b1;
            running_total++;
          end
        end
        KIND_STOP: begin
          if (running[ix]) begin
            running[ix] = 1'b0;
            running_total--;
          end
        end
        KIND_RESTART: begin
          armed_at[ix] = now_ticks;
          if (!running[ix]) begin
            running[ix] = 1'b1;
            running_total++;
          end
        end
        KIND_CONFIG: begin
          span[ix] = lm;
          repeats[ix] = r;
        end
        default: ;
      endcase
      el = now_ticks - armed_at[ix];
      rep = '{ix, 1'b0, el, (el >= span[ix]) ? '0 : span[ix] - el, running[ix], '0,
              fired_total, 1'b0};
      batch.push_back(rep);
    end
    foreach (batch[j]) begin
      batch[j].count = running_total;
      batch[j].is_last = (j == batch.size() - 1);
      pending_status.push_back(batch[j]);
    end
  endtask

  function automatic int unsigned draw_gap();
    return ((sent / 16) % 3 == 2) ? 0 : $urandom_range(0, 18);
  endfunction

  task automatic transfer(input logic [KIND_W-1:0] k, input logic [CH_W-1:0] ix,
                          input logic [TIME_W-1:0] lm, input logic r, input bit drain);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0 || drain) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain) begin
        do @(posedge clk); while (pending_status.size() != 0);
      end
    end
    start <= 1'b1;
    kind <= k;
    timer_index <= ix;
    limit_ms <= lm;
    recurring <= r;
    do @(posedge clk); while (busy);
    bank_step(k, ix, lm, r);
    sent++;
  endtask

  always @(posedge clk) begin : check
    status_t want;
    if (!rst && strobe) begin
      if (pending_status.size() == 0) begin
        flag($sformatf("unexpected result on channel %0d", channel));
      end else begin
        want = pending_status.pop_front();
        if (channel !== want.chan)
          flag($sformatf("channel got %0d want %0d", channel, want.chan));
        if (expiry_event !== want.expiry)
          flag($sformatf("expiry_event got %0b want %0b", expiry_event, want.expiry));
        if (elapsed_ms !== want.elapsed)
          flag($sformatf("elapsed_ms got %0d want %0d", elapsed_ms, want.elapsed));
        if (remaining_ms !== want.remain)
          flag($sformatf("remaining_ms got %0d want %0d", remaining_ms, want.remain));
        if (channel_active !== want.active)
          flag($sformatf("channel_active got %0b want %0b", channel_active, want.active));
        if (active_count !== want.count)
          flag($sformatf("active_count got %0d want %0d", active_count, want.count));
        if (total_expiries !== want.total)
          flag($sformatf("total_expiries got %0d want %0d", total_expiries, want.total));
        if (last !== want.is_last)
          flag($sformatf("last got %0b want %0b", last, want.is_last));
      end
    end
  end

  initial begin
    int unsigned pick;
    logic [KIND_W-1:0] k;
    bit burst_done;
    status_t typed_status;
    errors = 0;
    sent = 0;
    burst_done = 1'b0;
    rst <= 1'b1;
    start <= 1'b0;
    kind <= KIND_TICK;
    timer_index <= '0;
    limit_ms <= '0;
    recurring <= 1'b0;
    bank_reset();

    plan = '{
      '{KIND_STOP,     4'd0,  32'd0,        1'b0, 1'b1, 32'd0, 32'd5000,  1'b0, 5'd0, 32'd0},
      '{KIND_STOP,     4'd9,  32'd0,        1'b0, 1'b1, 32'd0, 32'd50,    1'b0, 5'd0, 32'd0},
      '{KIND_SPARE_A,  4'd15, 32'd0,        1'b0, 1'b1, 32'd0, 32'd1000,  1'b0, 5'd0, 32'd0},
      '{KIND_SPARE_B,  4'd8,  32'd0,        1'b0, 1'b1, 32'd0, 32'd30000, 1'b0, 5'd0, 32'd0},
      '{KIND_TICK,     4'd0,  32'd0,        1'b0, 1'b0, 32'd0, 32'd0,     1'b0, 5'd0, 32'd0},
      '{KIND_CONFIG,   4'd1,  32'd0,        1'b1, 1'b0, 32'd0, 32'd0,     1'b0, 5'd0, 32'd0},
      '{KIND_START,    4'd1,  32'd0,        1'b0, 1'b0, 32'd0, 32'd0,     1'b0, 5'd0, 32'd0},
      '{KIND_START,    4'd1,  32'd0,        1'b0, 1'b0, 32'd0, 32'd0,     1'b0, 5'd0, 32'd0},
      '{KIND_CONFIG,   4'd2,  32'd2,        1'b0, 1'b0, 32'd0, 32'd0,     1'b0, 5'd0, 32'd0},
      '{KIND_START,    4'd2,  32'd0,        1'b0, 1'b0, 32'd0, 32'd0,     1'b0, 5'd0, 32'd0},
      '{KIND_TICK,     4'd0,  32'd0,        1'b0, 1'b0, 32'd0, 32'd0,     1'b0, 5'd0, 32'd0},
      '{KIND_TICK,     4'd0,  32'd0,        1'b0, 1'b0, 32'd0, 32'd0,     1'b0, 5'd0, 32'd0},
      '{KIND_CONFIG,   4'd3,  32'hFFFFFFFF, 1'b1, 1'b0, 32'd0, 32'd0,     1'b0, 5'd0, 32'd0},
      '{KIND_RESTART,  4'd3,  32'd0,        1'b0, 1'b0, 32'd0, 32'd0,     1'b0, 5'd0, 32'd0},
      '{KIND_TICK,     4'd0,  32'd0,        1'b0, 1'b0, 32'd0, 32'd0,     1'b0, 5'd0, 32'd0},
      '{KIND_RESTART,  4'd3,  32'd0,        1'b0, 1'b0, 32'd0, 32'd0,     1'b0, 5'd0, 32'd0},
      '{KIND_STOP,     4'd3,  32'd0,        1'b0, 1'b0, 32'd0, 32'd0,     1'b0, 5'd0, 32'd0},
      '{KIND_STOP,     4'd3,  32'd0,        1'b0, 1'b0, 32'd0, 32'd0,     1'b0, 5'd0, 32'd0},
      '{KIND_CONFIG,   4'd15, 32'd0,        1'b0, 1'b0, 32'd0, 32'd0,     1'b0, 5'd0, 32'd0},
      '{KIND_START,    4'd15, 32'd0,        1'b0, 1'b0, 32'd0, 32'd0,     1'b0, 5'd0, 32'd0},
      '{KIND_CONFIG,   4'd0,  32'd0,        1'b1, 1'b0, 32'd0, 32'd0,     1'b0, 5'd0, 32'd0},
      '{KIND_START,    4'd0,  32'd0,        1'b0, 1'b0, 32'd0, 32'd0,     1'b0, 5'd0, 32'd0},
      '{KIND_TICK,     4'd0,  32'd0,        1'b0, 1'b0, 32'd0, 32'd0,     1'b0, 5'd0, 32'd0},
      '{KIND_STOP_ALL, 4'd9,  32'd0,        1'b0, 1'b1, 32'd5, 32'd45,    1'b0, 5'd0, 32'd7},
      '{KIND_TICK,     4'd0,  32'd0,        1'b0, 1'b0, 32'd0, 32'd0,     1'b0, 5'd0, 32'd0}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int row = 0; row < PLAN_ROWS; row++) begin
      transfer(plan[row].kind, plan[row].idx, plan[row].lim, plan[row].rec, 1'b0);
      if (plan[row].typed) begin
        void'(pending_status.pop_back());
        typed_status = '{plan[row].idx, 1'b0, plan[row].el, plan[row].rem, plan[row].act,
                         plan[row].cnt, plan[row].tot, 1'b1};
        pending_status.push_back(typed_status);
      end
    end

    transfer(KIND_STOP, 4'd0, '0, 1'b0, 1'b1);
    sent = 0;
    while (sent < RANDOM_GOAL) begin
      if ((sent >= 60 && !burst_done) || $urandom_range(0, 79) == 0) begin
        burst_done = 1'b1;
        for (int ch = 0; ch < CHANNELS; ch++)
          transfer(KIND_CONFIG, 4'(ch), $urandom_range(0, 3), 1'($urandom_range(0, 1)), 1'b0);
        for (int ch = 0; ch < CHANNELS; ch++)
          transfer(KIND_RESTART, 4'(ch), $urandom, 1'($urandom_range(0, 1)), 1'b0);
        repeat (4) transfer(KIND_TICK, 4'($urandom_range(0, 15)), $urandom, 1'b0, 1'b0);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45) k = KIND_TICK;
        else if (pick < 58) k = KIND_START;
        else if (pick < 66) k = KIND_STOP;
        else if (pick < 76) k = KIND_RESTART;
        else if (pick < 79) k = KIND_STOP_ALL;
        else if (pick < 95) k = KIND_CONFIG;
        else k = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
        transfer(k, 4'($urandom_range(0, 15)),
                 ($urandom_range(0, 9) < 7) ? $urandom_range(0, 12) : $urandom,
                 1'($urandom_range(0, 1)), $urandom_range(0, 19) == 0);
      end
    end

    start <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending_status.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/tmb_pkg.sv
rtl/tmb_ram.sv
rtl/tmb_eval.sv
rtl/timeout_timer_bank_unit.sv
verif/tb_timeout_timer_bank_unit.sv
